### src/anpr_pkg.sv
// Shared types, character codes and digit decoding for the ASCII number parser.
package anpr_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int VALUE_WIDTH_MIN     = 8;
   localparam int VALUE_WIDTH_MAX     = 64;
   localparam int OUT_WIDTH           = 64;
   localparam int CHAR_WIDTH          = 8;
   localparam int CSR_DATA_WIDTH      = 64;
   localparam int CSR_ADDR_WIDTH      = 4;
   localparam int CSR_INDEX_BIT       = 3;

   localparam logic CSR_MAX_VALUE_INDEX = 1'b0;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] HEX_LETTER_BASE = 8'd10;

   // character position, saturating after the second character
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_LATER  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_RANGE   = 2'd3
   } status_type;

   // per-text control state
   typedef struct packed {
      logic [1:0] char_pos;
      logic       hex_mode;
      logic       first_was_zero;
      status_type error_code;
   } ctrl_type;

   localparam ctrl_type CTRL_CLEAR = '{
      char_pos: POS_FIRST, hex_mode: 1'b0, first_was_zero: 1'b0, error_code: STATUS_OK
   };

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type digit_of(input logic [CHAR_WIDTH-1:0] c, input logic hex);
      digit_type d;
      d.valid = 1'b0;
      d.value = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d.valid = 1'b1;
         d.value = 4'(c - CHAR_ZERO);
      end else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d.valid = 1'b1;
         d.value = 4'(c - CHAR_LOWER_A + HEX_LETTER_BASE);
      end else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d.valid = 1'b1;
         d.value = 4'(c - CHAR_UPPER_A + HEX_LETTER_BASE);
      end
      return d;
   endfunction

endpackage

### src/anpr_if.sv
// Character and result channel interfaces of the ASCII number parser.
interface anpr_req_if import anpr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;
   logic                  no_char;
   logic                  last;

   modport source (output valid, char_code, no_char, last, input ready);
   modport sink   (input valid, char_code, no_char, last, output ready);
endinterface

interface anpr_rsp_if import anpr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_WIDTH-1:0] parsed_value;
   logic [1:0]           status;

   modport source (output valid, parsed_value, status, input ready);
   modport sink   (input valid, parsed_value, status, output ready);
endinterface

### src/anpr_step.sv
// One-character update of the parser state: prefix detection, digit decode, MAC and range test.
module anpr_step import anpr_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  ctrl_type                ctrl_cur,
   input  logic [VALUE_WIDTH-1:0]  acc_cur,
   input  logic [VALUE_WIDTH-1:0]  eff_max,
   input  logic [CHAR_WIDTH-1:0]   char_code,
   input  logic                    no_char,
   output ctrl_type                ctrl_nxt,
   output logic [VALUE_WIDTH-1:0]  acc_nxt
);

   // acc*16 + 15 fits in VALUE_WIDTH+4 bits; one spare bit
   localparam int SUM_WIDTH = VALUE_WIDTH + 5;

   digit_type              dig;
   logic [SUM_WIDTH-1:0]   scaled;
   logic [SUM_WIDTH-1:0]   sum;
   logic                   is_prefix;

   always_comb begin
      ctrl_nxt = ctrl_cur;
      acc_nxt  = acc_cur;
      dig      = digit_of(char_code, ctrl_cur.hex_mode);
      // x16 is a shift, x10 is x8 + x2
      scaled   = ctrl_cur.hex_mode ? {1'b0, acc_cur, 4'b0000}
                                   : ({2'b00, acc_cur, 3'b000} + {4'b0000, acc_cur, 1'b0});
      sum      = scaled + SUM_WIDTH'(dig.value);
      is_prefix = (ctrl_cur.char_pos == POS_SECOND) && !ctrl_cur.hex_mode &&
                  ctrl_cur.first_was_zero &&
                  (char_code == CHAR_LOWER_X || char_code == CHAR_UPPER_X);

      if (!no_char && ctrl_cur.error_code == STATUS_OK) begin
         if (is_prefix) begin
            // prefix pending, position held
            ctrl_nxt.hex_mode = 1'b1;
         end else begin
            if (ctrl_cur.char_pos == POS_FIRST) begin
               ctrl_nxt.first_was_zero = (char_code == CHAR_ZERO);
            end
            if (!dig.valid) begin
               ctrl_nxt.error_code = STATUS_INVALID;
            end else if (sum > SUM_WIDTH'(eff_max)) begin
               ctrl_nxt.error_code = STATUS_RANGE;
            end else begin
               acc_nxt = sum[VALUE_WIDTH-1:0];
            end
            if (ctrl_cur.char_pos != POS_LATER) begin
               ctrl_nxt.char_pos = ctrl_cur.char_pos + 2'd1;
            end
         end
      end
   end

endmodule

### src/ascii_number_parser_range_check_unit.sv
// Top level of the ASCII number parser with range check.
//
// Parses unsigned decimal or hexadecimal ("0x"/"0X" prefix) text arriving one character
// per req transfer and returns one rsp transfer (value and status) for the transfer marked
// last. Throughput is one character per clock unless the stall below holds the input: the
// character is captured in an input register, and the combinational multiply-by-base,
// add and compare against the maximum update the accumulator register, which loads
// together with the result register for the last character of a text. A result thus
// goes through the input register and then the result register. The input side keeps
// taking characters while a result waits in the output register; it stalls only when a
// second result would be produced before the first is taken. Status: 0 ok, 1 empty text,
// 2 invalid digit, 3 out of range; the value reads as zero unless status is 0. The first
// error of a text is kept and later characters are ignored until the last one. The
// maximum register (byte address 0, 64 bits) resets to all ones; the limit applied is the
// smaller of it and the largest VALUE_WIDTH-bit value. Write it only while no text is in
// flight.
module ascii_number_parser_range_check_unit import anpr_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   anpr_req_if.sink                  req,
   anpr_rsp_if.source                rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   // ---------------------------------------------------------------- register port
   logic [CSR_DATA_WIDTH-1:0] max_value_ff, max_value_in;
   logic [VALUE_WIDTH-1:0]    eff_max_ff, eff_max_in;
   logic                      csr_sel_max;
   logic                      csr_write;

   assign pready      = 1'b1;
   assign csr_sel_max = (paddr[CSR_INDEX_BIT] == CSR_MAX_VALUE_INDEX);
   assign csr_write   = psel && penable && pwrite && csr_sel_max;
   assign prdata      = csr_sel_max ? max_value_ff : '0;

   // effective limit is worked out at write time to keep it off the MAC path
   always_comb begin
      max_value_in = max_value_ff;
      eff_max_in   = eff_max_ff;
      if (csr_write) begin
         max_value_in = pwdata;
         eff_max_in   = (|(pwdata >> VALUE_WIDTH)) ? '1 : pwdata[VALUE_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------- input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [CHAR_WIDTH-1:0] s1_char_ff;
   logic                  s1_no_char_ff;
   logic                  s1_last_ff;
   logic                  s1_advance;
   logic                  req_xfer;

   // a character moves on unless it finishes a text and the result slot is still full
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp.valid || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign req_xfer   = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- text state
   ctrl_type               ctrl_ff, ctrl_in, step_ctrl;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in, step_acc;

   anpr_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_step (
      .ctrl_cur  (ctrl_ff),
      .acc_cur   (acc_ff),
      .eff_max   (eff_max_ff),
      .char_code (s1_char_ff),
      .no_char   (s1_no_char_ff),
      .ctrl_nxt  (step_ctrl),
      .acc_nxt   (step_acc)
   );

   // state clears after the last character of a text
   always_comb begin
      ctrl_in = ctrl_ff;
      acc_in  = acc_ff;
      if (s1_advance) begin
         ctrl_in = s1_last_ff ? CTRL_CLEAR : step_ctrl;
         acc_in  = s1_last_ff ? '0 : step_acc;
      end
   end

   // ---------------------------------------------------------------- result
   status_type            final_status;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;

   // bare "0x" counts as an invalid text
   always_comb begin
      final_status = step_ctrl.error_code;
      if (final_status == STATUS_OK) begin
         if (step_ctrl.hex_mode && step_ctrl.char_pos == POS_SECOND) begin
            final_status = STATUS_INVALID;
         end else if (step_ctrl.char_pos == POS_FIRST) begin
            final_status = STATUS_EMPTY;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = final_status;
         rsp_value_in  = (final_status == STATUS_OK) ? OUT_WIDTH'(step_acc) : '0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.parsed_value = rsp_value_ff;
   assign rsp.status       = rsp_status_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff <= '1;
         eff_max_ff   <= '1;
         s1_valid_ff  <= 1'b0;
         ctrl_ff      <= CTRL_CLEAR;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_value_ff <= max_value_in;
         eff_max_ff   <= eff_max_in;
         s1_valid_ff  <= s1_valid_in;
         ctrl_ff      <= ctrl_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_char_ff    <= req.char_code;
         s1_no_char_ff <= req.no_char;
         s1_last_ff    <= req.last;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ---------------------------------------------------------------- assertions
   // a finished text never overwrites a result that is still waiting
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |-> !rsp_valid_ff || rsp.ready)
      else $error("result register overwritten");

   // state is clean after the last character of a text
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> ctrl_ff == CTRL_CLEAR && acc_ff == '0)
      else $error("text state not cleared after last transfer");

   // hex mode only after a leading zero
   a_hex_needs_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.hex_mode |-> ctrl_ff.first_was_zero)
      else $error("hex mode without leading zero");

   // an error result carries a zero value
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_value_ff == '0)
      else $error("non-zero value with error status");

endmodule
